// File: hdl/assert_macros.svh
// assertion macros for the chordal error jacobian checker
// depends on nothing; callers supply clock, reset and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SEJ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SEJ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sej_pkg.sv
// shared types, codes and saturating helpers for the chordal error jacobian core
// depends on nothing
package sej_pkg;

   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 4;
   localparam int DOT_COUNT = 5;

   localparam logic [KIND_W-1:0] KIND_FROM    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TO      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MEAS    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd3;

   localparam logic [INDEX_W-1:0] ROW_LAST  = 4'd11;
   localparam logic [INDEX_W-1:0] ROW_TRANS = 4'd9;

   localparam logic [2:0] DOT_LAST  = 3'd4;
   localparam logic [1:0] TERM_LAST = 2'd2;

   localparam logic [1:0] B_ZERO = 2'd0;
   localparam logic [1:0] B_POS  = 2'd1;
   localparam logic [1:0] B_NEG  = 2'd2;

   localparam logic [4:0] TO_BASE = 5'd16;

   localparam int GEN_TAB [3][9] = '{
      '{0, 0, 0, 0, 0, -1, 0, 1, 0},
      '{0, 0, 1, 0, 0, 0, -1, 0, 0},
      '{0, -1, 0, 1, 0, 0, 0, 0, 0}
   };

   typedef struct packed {
      logic [INDEX_W-1:0] a_addr;
      logic [4:0]         b_addr;
      logic               a_neg;
      logic [1:0]         b_mode;
   } sej_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] dot;
      logic [1:0] term;
      logic       a_neg;
      logic [1:0] b_mode;
   } sej_step_type;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   function automatic logic signed [WORD_W-1:0] sat_64(input logic signed [63:0] v);
      logic signed [WORD_W-1:0] res;
      if (v > 64'(WORD_MAX)) begin
         res = WORD_MAX;
      end else if (v < 64'(WORD_MIN)) begin
         res = WORD_MIN;
      end else begin
         res = v[WORD_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_33(input logic signed [WORD_W:0] v);
      logic signed [WORD_W-1:0] res;
      if (v[WORD_W] != v[WORD_W-1]) begin
         res = v[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
         res = v[WORD_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = 33'(a) + 33'(b);
      return sat_33(s);
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = 33'(a) - 33'(b);
      return sat_33(s);
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_neg(input logic signed [WORD_W-1:0] a);
      logic signed [WORD_W-1:0] res;
      res = (a == WORD_MIN) ? WORD_MAX : -a;
      return res;
   endfunction

   // operand addresses and signs for one product of one row
   function automatic sej_ctrl_type sej_step_ctrl(input logic [INDEX_W-1:0] row,
                                                  input logic [2:0] dot,
                                                  input logic [1:0] term);
      sej_ctrl_type ctl;
      int r;
      int c;
      int k;
      int g;
      int kk;
      int sel;
      ctl = '0;
      ctl.b_mode = B_ZERO;
      k = int'(term);
      if (row < ROW_TRANS) begin
         c = (row >= 4'd6) ? 2 : ((row >= 4'd3) ? 1 : 0);
         r = int'(row) - 3 * c;
         ctl.a_addr = 4'(r * 3 + k);
         if (dot == 3'd0) begin
            ctl.b_addr = TO_BASE + 5'(c * 3 + k);
            ctl.b_mode = B_POS;
         end else if (dot <= 3'd3) begin
            g = int'(dot) - 1;
            for (kk = 0; kk < 3; kk++) begin
               if (GEN_TAB[g][k * 3 + kk] != 0) begin
                  ctl.b_addr = TO_BASE + 5'(c * 3 + kk);
                  ctl.b_mode = (GEN_TAB[g][k * 3 + kk] > 0) ? B_POS : B_NEG;
               end
            end
         end
      end else begin
         r = int'(row) - 9;
         ctl.a_addr = 4'(r * 3 + k);
         if (dot == 3'd0) begin
            ctl.b_addr = TO_BASE + 5'(9 + k);
            ctl.b_mode = B_POS;
         end else if (dot == DOT_LAST) begin
            ctl.b_addr = 5'(9 + k);
            ctl.b_mode = B_POS;
         end else begin
            ctl.a_neg = 1'b1;
            sel = k * 3 + int'(dot) - 1;
            unique case (sel)
               1: begin ctl.b_addr = TO_BASE + 5'd11; ctl.b_mode = B_NEG; end
               2: begin ctl.b_addr = TO_BASE + 5'd10; ctl.b_mode = B_POS; end
               3: begin ctl.b_addr = TO_BASE + 5'd11; ctl.b_mode = B_POS; end
               5: begin ctl.b_addr = TO_BASE + 5'd9;  ctl.b_mode = B_NEG; end
               6: begin ctl.b_addr = TO_BASE + 5'd10; ctl.b_mode = B_NEG; end
               7: begin ctl.b_addr = TO_BASE + 5'd9;  ctl.b_mode = B_POS; end
               default: begin ctl.b_mode = B_ZERO; end
            endcase
         end
      end
      return ctl;
   endfunction

endpackage

// File: hdl/sej_if.sv
// request and response channel interfaces
// depends on sej_pkg
interface sej_req_if import sej_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [INDEX_W-1:0]       index;
   logic signed [WORD_W-1:0] value;
   logic                     error_only;

   modport source (output valid, kind, index, value, error_only, input ready);
   modport sink (input valid, kind, index, value, error_only, output ready);
endinterface

interface sej_rsp_if import sej_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [INDEX_W-1:0]       row;
   logic signed [WORD_W-1:0] error_value;
   logic signed [WORD_W-1:0] jac_tx;
   logic signed [WORD_W-1:0] jac_ty;
   logic signed [WORD_W-1:0] jac_tz;
   logic signed [WORD_W-1:0] jac_rx;
   logic signed [WORD_W-1:0] jac_ry;
   logic signed [WORD_W-1:0] jac_rz;
   logic                     last;

   modport source (output valid, row, error_value, jac_tx, jac_ty, jac_tz,
                   jac_rx, jac_ry, jac_rz, last, input ready);
   modport sink (input valid, row, error_value, jac_tx, jac_ty, jac_tz,
                 jac_rx, jac_ry, jac_rz, last, output ready);
endinterface

// File: hdl/sej_ram.sv
// generic single write port ram with registered read
// depends on nothing
module sej_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/sej_mac.sv
// multiply, round, saturate and accumulate datapath fed by the pose memories
// depends on sej_pkg
module sej_mac import sej_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sej_step_type             step,
   input  logic signed [WORD_W-1:0] a_data,
   input  logic signed [WORD_W-1:0] b_data,
   output logic signed [WORD_W-1:0] acc [DOT_COUNT],
   output logic signed [WORD_W-1:0] jt [3]
);
   localparam logic signed [63:0] RND = 64'sd1 <<< (FRACTION_BITS - 1);

   sej_step_type             stage1_ff, stage2_ff;
   logic signed [WORD_W-1:0] a_op, b_op;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [63:0]       shifted;
   logic signed [WORD_W-1:0] p32;
   logic signed [WORD_W-1:0] acc_ff [DOT_COUNT];
   logic signed [WORD_W-1:0] acc_in [DOT_COUNT];
   logic signed [WORD_W-1:0] jt_ff [3];
   logic signed [WORD_W-1:0] jt_in [3];

   always_comb begin
      a_op = stage1_ff.a_neg ? sat_neg(a_data) : a_data;
      case (stage1_ff.b_mode)
         B_POS:   b_op = b_data;
         B_NEG:   b_op = sat_neg(b_data);
         default: b_op = '0;
      endcase
      prod_in = 64'(a_op) * 64'(b_op);
   end

   always_comb begin
      shifted = (prod_ff + RND) >>> FRACTION_BITS;
      p32 = sat_64(shifted);
      acc_in = acc_ff;
      if (stage2_ff.valid) begin
         acc_in[stage2_ff.dot] = (stage2_ff.term == 2'd0) ? p32
                                 : sat_add(acc_ff[stage2_ff.dot], p32);
      end
      jt_in = jt_ff;
      if (stage1_ff.valid && stage1_ff.dot == 3'd0) begin
         jt_in[stage1_ff.term] = a_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= '0;
         stage2_ff <= '0;
      end else begin
         stage1_ff <= step;
         stage2_ff <= stage1_ff;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      jt_ff   <= jt_in;
   end

   assign acc = acc_ff;
   assign jt  = jt_ff;
endmodule

// File: hdl/se3_chordal_error_jacobian_core.sv
// load beats produce nothing; a compute beat gives 12 result beats, each taking 15
// product steps through the shared multiplier, then a drain state and an emit state
// that holds while the response channel stalls; one item at a time.
// the single multiplier and the single read port per pose memory make the products run one after another.
// reset clears control only; pose memories hold undefined words until written.
module se3_chordal_error_jacobian_core import sej_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sej_req_if.sink   req_if,
   sej_rsp_if.source rsp_if
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [INDEX_W-1:0] row_ff, row_in;
   logic [2:0]         dot_ff, dot_in;
   logic [1:0]         term_ff, term_in;
   logic               drain_ff, drain_in;
   logic               err_only_ff, err_only_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_row_ff, rsp_row_in;
   logic signed [WORD_W-1:0] rsp_err_ff, rsp_err_in;
   logic signed [WORD_W-1:0] rsp_jac_ff [6];
   logic signed [WORD_W-1:0] rsp_jac_in [6];
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_beat, load;
   logic                     wa_en, wb_en, wm_en;
   logic [4:0]               wb_addr;
   sej_ctrl_type             ctrl;
   sej_step_type             step;
   logic signed [WORD_W-1:0] a_data, b_data, m_data;
   logic signed [WORD_W-1:0] acc [DOT_COUNT];
   logic signed [WORD_W-1:0] jt [3];
   logic signed [WORD_W-1:0] pred;
   logic                     emit;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_beat = req_if.valid && req_if.ready;
   assign load = req_beat && (req_if.kind != KIND_COMPUTE) && (req_if.index <= ROW_LAST);
   assign wa_en = load && (req_if.kind == KIND_FROM);
   assign wb_en = load && (req_if.kind == KIND_FROM || req_if.kind == KIND_TO);
   assign wm_en = load && (req_if.kind == KIND_MEAS);
   assign wb_addr = {req_if.kind == KIND_TO, req_if.index};

   assign ctrl = sej_step_ctrl(row_ff, dot_ff, term_ff);

   always_comb begin
      step.valid  = (state_ff == ST_RUN);
      step.dot    = dot_ff;
      step.term   = term_ff;
      step.a_neg  = ctrl.a_neg;
      step.b_mode = ctrl.b_mode;
   end

   sej_ram #(.WIDTH(WORD_W), .DEPTH(12)) u_ram_from (
      .clock   (clock),
      .wr_en   (wa_en),
      .wr_addr (req_if.index),
      .wr_data (req_if.value),
      .rd_addr (ctrl.a_addr),
      .rd_data (a_data)
   );

   sej_ram #(.WIDTH(WORD_W), .DEPTH(32)) u_ram_pose (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_addr),
      .wr_data (req_if.value),
      .rd_addr (ctrl.b_addr),
      .rd_data (b_data)
   );

   sej_ram #(.WIDTH(WORD_W), .DEPTH(12)) u_ram_meas (
      .clock   (clock),
      .wr_en   (wm_en),
      .wr_addr (req_if.index),
      .wr_data (req_if.value),
      .rd_addr (row_ff),
      .rd_data (m_data)
   );

   sej_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .a_data (a_data),
      .b_data (b_data),
      .acc    (acc),
      .jt     (jt)
   );

   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      dot_in      = dot_ff;
      term_in     = term_ff;
      drain_in    = drain_ff;
      err_only_in = err_only_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_if.kind == KIND_COMPUTE) begin
               state_in    = ST_RUN;
               row_in      = '0;
               dot_in      = '0;
               term_in     = '0;
               err_only_in = req_if.error_only;
            end
         end
         ST_RUN: begin
            if (term_ff == TERM_LAST) begin
               term_in = '0;
               dot_in  = dot_ff + 3'd1;
               if (dot_ff == DOT_LAST) begin
                  state_in = ST_DRAIN;
                  drain_in = 1'b0;
               end
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               dot_in  = '0;
               term_in = '0;
               if (row_ff == ROW_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  row_in   = row_ff + 4'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pred = (row_ff < ROW_TRANS) ? acc[0] : sat_sub(acc[0], acc[4]);
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_jac_in   = rsp_jac_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = row_ff;
         rsp_err_in   = sat_sub(pred, m_data);
         rsp_last_in  = (row_ff == ROW_LAST);
         if (err_only_ff) begin
            rsp_jac_in = '{default: '0};
         end else if (row_ff < ROW_TRANS) begin
            rsp_jac_in = '{32'sd0, 32'sd0, 32'sd0, acc[1], acc[2], acc[3]};
         end else begin
            rsp_jac_in = '{jt[0], jt[1], jt[2], acc[1], acc[2], acc[3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         dot_ff       <= '0;
         term_ff      <= '0;
         drain_ff     <= 1'b0;
         err_only_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         dot_ff       <= dot_in;
         term_ff      <= term_in;
         drain_ff     <= drain_in;
         err_only_ff  <= err_only_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_row_ff  <= rsp_row_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_jac_ff  <= rsp_jac_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.row         = rsp_row_ff;
   assign rsp_if.error_value = rsp_err_ff;
   assign rsp_if.jac_tx      = rsp_jac_ff[0];
   assign rsp_if.jac_ty      = rsp_jac_ff[1];
   assign rsp_if.jac_tz      = rsp_jac_ff[2];
   assign rsp_if.jac_rx      = rsp_jac_ff[3];
   assign rsp_if.jac_ry      = rsp_jac_ff[4];
   assign rsp_if.jac_rz      = rsp_jac_ff[5];
   assign rsp_if.last        = rsp_last_ff;
endmodule

// File: hdl/sej_checker.sv
// port level checks for the chordal error jacobian core, bound to the top level
// depends on sej_pkg and assert_macros.svh
`include "assert_macros.svh"

module sej_checker import sej_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [KIND_W-1:0]        req_kind,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [INDEX_W-1:0]       rsp_row,
   input logic signed [WORD_W-1:0] rsp_error_value,
   input logic                     rsp_last
);
   `SEJ_ASSERT_IMP(a_last_row, clock, reset, rsp_valid, rsp_last == (rsp_row == ROW_LAST), "last flag does not match final row")
   `SEJ_ASSERT_IMP(a_row_range, clock, reset, rsp_valid, rsp_row <= ROW_LAST, "row beyond range")
   `SEJ_ASSERT_IMP(a_busy_mid_run, clock, reset, rsp_valid && !rsp_last, !req_ready, "request taken during a run")
   `SEJ_ASSERT_NXT(a_compute_busy, clock, reset, req_valid && req_ready && req_kind == KIND_COMPUTE, !req_ready, "ready after compute beat")
   `SEJ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row) && $stable(rsp_error_value), "stalled beat changed")
endmodule

bind se3_chordal_error_jacobian_core sej_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_kind        (req_if.kind),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_row         (rsp_if.row),
   .rsp_error_value (rsp_if.error_value),
   .rsp_last        (rsp_if.last)
);
